// ===== hw/rtl/fratrk_pkg.sv =====
// ----------------------------------------------------------------------------
// fratrk_pkg: shared types and codes of the fragment reassembly tracker
// Beat layouts, status and event codes, cell view and chain structs.
// ----------------------------------------------------------------------------
package fratrk_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MAX_FRAGS_DEF = 16;
    localparam int SLOT_LIMIT    = 16;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    typedef struct packed {
        logic        command;
        logic [31:0] session_id;
        logic [31:0] sequence_req;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [4:0]  total_fragments;
        logic [3:0]  fragment_index;
        logic [15:0] buffer_handle;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  event_res;
        logic [31:0] done_session;
        logic [31:0] done_sequence;
        logic [31:0] done_ip;
        logic [15:0] done_port;
        logic [4:0]  done_total;
        logic [3:0]  slot_position;
        logic        slot_present;
        logic [15:0] slot_handle;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_DUP      = 3'd3,
        ST_BAD      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_TIMEOUT  = 2'd2
    } t_event;

    localparam logic CMD_FRAG = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_ACT,
        S_EMIT
    } t_state;

    // Priority chain passed from cell to cell: "some lower cell already has it"
    typedef struct packed {
        logic hit;
        logic spare;
        logic expired;
    } t_chain;

    // Per-cell commands
    typedef struct packed {
        logic alloc;
        logic write;
        logic free;
    } t_cell_ctl;

    // Cell contents, zero unless the cell is selected
    typedef struct packed {
        logic [31:0] session;
        logic [31:0] sequence_no;
        logic [31:0] address;
        logic [15:0] port;
        logic [4:0]  total;
        logic [4:0]  received;
        logic [SLOT_LIMIT-1:0] bitmap;
        logic        present;
        logic [15:0] handle;
    } t_view;

endpackage

// ===== hw/rtl/fratrk_cell.sv =====
// ----------------------------------------------------------------------------
// fratrk_cell: one table entry of the reassembly tracker
// Holds key, count, bitmap, birth tick and fragment handles of one datagram.
// ----------------------------------------------------------------------------
module fratrk_cell #(
    parameter int MAX_FRAGS = fratrk_pkg::MAX_FRAGS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fratrk_pkg::t_item    i_item,
    input  logic [31:0]          i_tick,
    input  logic [15:0]          i_timeout,
    input  fratrk_pkg::t_chain   i_prev,
    output fratrk_pkg::t_chain   o_next,
    output fratrk_pkg::t_chain   o_first,
    input  fratrk_pkg::t_cell_ctl i_ctl,
    input  logic                 i_sel,
    input  logic [3:0]           i_rd_slot,
    output fratrk_pkg::t_view    o_view
);
    import fratrk_pkg::*;

    localparam int SLOTS  = (MAX_FRAGS < SLOT_LIMIT) ? MAX_FRAGS : SLOT_LIMIT;
    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic              r_valid;
    logic [31:0]       r_session, r_sequence, r_address, r_birth;
    logic [15:0]       r_port;
    logic [4:0]        r_total, r_received;
    logic [SLOTS-1:0]  r_bitmap;
    logic [15:0]       r_handle [SLOTS];

    logic              own_hit, own_spare, own_exp;
    logic [31:0]       age;
    logic [SIDX_W-1:0] wr_idx, rd_idx;
    logic [SLOTS-1:0]  base_map;
    logic [SLOT_LIMIT-1:0] wide_map;

    assign age       = i_tick - r_birth;
    assign own_hit   = r_valid && r_session == i_item.session_id
                       && r_sequence == i_item.sequence_req
                       && r_address == i_item.source_ip
                       && r_port == i_item.source_port;
    assign own_spare = !r_valid;
    assign own_exp   = r_valid && (age >= {16'd0, i_timeout});

    assign o_next  = '{hit: i_prev.hit | own_hit, spare: i_prev.spare | own_spare,
                       expired: i_prev.expired | own_exp};
    assign o_first = '{hit: own_hit & !i_prev.hit, spare: own_spare & !i_prev.spare,
                       expired: own_exp & !i_prev.expired};

    assign wr_idx   = i_item.fragment_index[SIDX_W-1:0];
    assign rd_idx   = i_rd_slot[SIDX_W-1:0];
    assign base_map = i_ctl.alloc ? '0 : r_bitmap;
    assign wide_map = SLOT_LIMIT'(r_bitmap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.free) begin
            r_valid <= 1'b0;
        end else if (i_ctl.alloc) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_session  <= i_item.session_id;
            r_sequence <= i_item.sequence_req;
            r_address  <= i_item.source_ip;
            r_port     <= i_item.source_port;
            r_total    <= i_item.total_fragments;
            r_birth    <= i_tick;
        end
        if (i_ctl.write) begin
            r_bitmap         <= base_map | (SLOTS'(1) << wr_idx);
            r_received       <= (i_ctl.alloc ? 5'd0 : r_received) + 5'd1;
            r_handle[wr_idx] <= i_item.buffer_handle;
        end
    end

    always_comb begin
        o_view = '0;
        if (i_sel) begin
            o_view.session     = r_session;
            o_view.sequence_no = r_sequence;
            o_view.address     = r_address;
            o_view.port        = r_port;
            o_view.total       = r_total;
            o_view.received    = r_received;
            o_view.bitmap      = wide_map;
            o_view.present     = r_bitmap[rd_idx];
            o_view.handle      = r_handle[rd_idx];
        end
    end

endmodule

// ===== hw/rtl/fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker: datagram fragment reassembly table
// Row of entry cells with lookup, allocate, complete and expire sequencing.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  command   start, i_item, busy          taken when start & !busy
//  result    o_strobe, o_res              single-cycle strobe per beat, no backpressure
//  config    i_cfg_we, i_cfg_data         written when i_cfg_we
//
//  A command passes the states accept, cell lookup and decide, then emits one
//  result beat per slot of the entry on completion or timeout; the lookup over
//  the cell chain and the slot-by-slot read of one cell are the main steps.
//  busy stays high until the last result beat is registered.
//  Synchronous reset clears entry valid bits, tick counter and timeout (1000).
//  Results cannot be stalled: each beat is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
    parameter int ENTRIES   = fratrk_pkg::ENTRIES_DEF,
    parameter int MAX_FRAGS = fratrk_pkg::MAX_FRAGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  fratrk_pkg::t_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output fratrk_pkg::t_res   o_res,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);
    import fratrk_pkg::*;

    t_state          r_state, n_state;
    t_item           r_item;
    logic [31:0]     r_tick, n_tick;
    logic [15:0]     r_expire_ticks;
    logic [ENTRIES-1:0] r_hit, r_spare, r_exp;
    logic            r_any_hit, r_any_spare, r_any_exp;
    logic [ENTRIES-1:0] r_tgt, n_tgt;
    logic [3:0]      r_cnt, n_cnt;
    logic [1:0]      r_event, n_event;
    logic            r_strobe, n_strobe;
    t_res            r_res, n_res;

    t_chain          chain [ENTRIES+1];
    t_chain          first [ENTRIES];
    t_view           views [ENTRIES];
    t_view           view;
    t_cell_ctl       ctl   [ENTRIES];
    logic [ENTRIES-1:0] sel, act_tgt;

    logic            is_frag, bad, alloc, write_frag, complete;
    logic [4:0]      new_count;

    assign is_frag = (r_item.command == CMD_FRAG);
    assign bad = r_item.total_fragments == 5'd0
                 || 32'(r_item.total_fragments) > 32'(MAX_FRAGS)
                 || r_item.total_fragments > 5'(SLOT_LIMIT)
                 || {1'b0, r_item.fragment_index} >= r_item.total_fragments;

    // ---- cell row: priority chain ripples from cell 0 upward
    assign chain[0] = '0;
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            fratrk_cell #(.MAX_FRAGS(MAX_FRAGS)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_item    (r_item),
                .i_tick    (r_tick),
                .i_timeout (r_expire_ticks),
                .i_prev    (chain[g]),
                .o_next    (chain[g+1]),
                .o_first   (first[g]),
                .i_ctl     (ctl[g]),
                .i_sel     (sel[g]),
                .i_rd_slot (r_cnt),
                .o_view    (views[g])
            );
        end
    endgenerate

    // Only one cell is selected, so an OR gathers its view
    always_comb begin
        view = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            view = view | views[k];
        end
    end

    // Decide target: hit entry, else first spare; on a tick the first expired
    assign act_tgt = !is_frag ? r_exp : (r_any_hit ? r_hit : r_spare);
    assign sel     = (r_state == S_ACT) ? act_tgt : r_tgt;

    always_comb begin
        write_frag = 1'b0;
        if (r_state == S_ACT && is_frag && !bad) begin
            if (r_any_hit) begin
                write_frag = view.total == r_item.total_fragments
                             && !view.bitmap[r_item.fragment_index];
            end else begin
                write_frag = r_any_spare;
            end
        end
    end
    assign alloc     = write_frag && !r_any_hit;
    assign new_count = (alloc ? 5'd0 : view.received) + 5'd1;
    assign complete  = new_count >= r_item.total_fragments;

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            ctl[k].alloc = alloc && act_tgt[k];
            ctl[k].write = write_frag && act_tgt[k];
            ctl[k].free  = (r_state == S_EMIT) && r_tgt[k]
                           && ({1'b0, r_cnt} + 5'd1 == view.total);
        end
    end

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_LOOK;
            end
            S_LOOK: n_state = S_ACT;
            S_ACT: begin
                if (!is_frag) begin
                    n_state = r_any_exp ? S_EMIT : S_IDLE;
                end else begin
                    n_state = (write_frag && complete) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if ({1'b0, r_cnt} + 5'd1 == view.total) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs and datapath
    always_comb begin
        n_tick   = r_tick;
        n_tgt    = r_tgt;
        n_cnt    = r_cnt;
        n_event  = r_event;
        n_strobe = 1'b0;
        n_res    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_item.command != CMD_FRAG) n_tick = r_tick + 32'd1;
            end
            S_LOOK: ;
            S_ACT: begin
                n_tgt = act_tgt;
                n_cnt = '0;
                n_res.last = 1'b1;
                if (!is_frag) begin
                    n_event  = EV_TIMEOUT;
                    n_strobe = !r_any_exp;
                end else begin
                    n_event  = EV_COMPLETE;
                    n_strobe = !(write_frag && complete);
                    if (bad) begin
                        n_res.status = ST_BAD;
                    end else if (!r_any_hit && !r_any_spare) begin
                        n_res.status = ST_FULL;
                    end else if (r_any_hit && view.total != r_item.total_fragments) begin
                        n_res.status = ST_MISMATCH;
                    end else if (r_any_hit && view.bitmap[r_item.fragment_index]) begin
                        n_res.status = ST_DUP;
                    end
                end
            end
            S_EMIT: begin
                n_strobe            = 1'b1;
                n_cnt               = r_cnt + 4'd1;
                n_res.event_res     = r_event;
                n_res.done_session  = view.session;
                n_res.done_sequence = view.sequence_no;
                n_res.done_ip       = view.address;
                n_res.done_port     = view.port;
                n_res.done_total    = view.total;
                n_res.slot_position = r_cnt;
                n_res.slot_present  = view.present;
                n_res.slot_handle   = view.present ? view.handle : 16'd0;
                n_res.last          = ({1'b0, r_cnt} + 5'd1 == view.total);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tick         <= '0;
            r_expire_ticks <= TIMEOUT_RST;
            r_strobe       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_strobe <= n_strobe;
            if (i_cfg_we) r_expire_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        // hold the command beat for the whole transaction
        if (r_state == S_IDLE && start) r_item <= i_item;
        if (r_state == S_LOOK) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_hit[k]   <= first[k].hit;
                r_spare[k] <= first[k].spare;
                r_exp[k]   <= first[k].expired;
            end
            r_any_hit   <= chain[ENTRIES].hit;
            r_any_spare <= chain[ENTRIES].spare;
            r_any_exp   <= chain[ENTRIES].expired;
        end
        r_tgt   <= n_tgt;
        r_cnt   <= n_cnt;
        r_event <= n_event;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // ---- checks
    a_tgt_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> $onehot(r_tgt))
        else $error("emit target not one-hot");
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> {1'b0, r_cnt} < view.total)
        else $error("emit slot past total");
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a command in flight");

endmodule

// ===== tb/fragment_reassembly_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_tb: self-checking bench of the reassembly table
// Drives fragment and tick commands with random gaps and predicts every
// result beat. A scoreboard compares each beat field by field in order.
// ----------------------------------------------------------------------------
import fratrk_pkg::*;

class reassembly_scoreboard;
    t_res        pending_q[$];
    logic [15:0] timeout;
    logic [31:0] tick;
    bit          valid[16];
    logic [31:0] sess[16];
    logic [31:0] seqn[16];
    logic [31:0] addr[16];
    logic [15:0] port[16];
    logic [4:0]  total[16];
    logic [4:0]  rcvd[16];
    logic [15:0] bitmap[16];
    logic [31:0] birth[16];
    logic [15:0] handles[16][16];
    int          errors;

    function new();
        timeout = TIMEOUT_RST;
        tick    = '0;
        errors  = 0;
        foreach (valid[e]) valid[e] = 0;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void push_status(t_status s);
        t_res r;
        r        = '0;
        r.status = s;
        r.last   = 1'b1;
        pending_q.push_back(r);
    endfunction

    // Queue one beat per slot of the entry, then free it
    function void release_entry(int e, t_event ev);
        t_res r;
        for (int i = 0; i < total[e]; i++) begin
            r               = '0;
            r.status        = ST_OK;
            r.event_res     = ev;
            r.done_session  = sess[e];
            r.done_sequence = seqn[e];
            r.done_ip       = addr[e];
            r.done_port     = port[e];
            r.done_total    = total[e];
            r.slot_position = i[3:0];
            r.slot_present  = bitmap[e][i];
            r.slot_handle   = bitmap[e][i] ? handles[e][i] : 16'h0;
            r.last          = (i + 1 == total[e]);
            pending_q.push_back(r);
        end
        valid[e] = 0;
    endfunction

    function void note_item(t_item it);
        int hit;
        int spare;
        int e;
        hit   = -1;
        spare = -1;
        if (it.command != CMD_FRAG) begin
            tick = tick + 32'd1;
            for (e = 0; e < 16; e++) begin
                if (valid[e] && (tick - birth[e]) >= {16'h0, timeout}) begin
                    release_entry(e, EV_TIMEOUT);
                    return;
                end
            end
            push_status(ST_OK);
            return;
        end
        if (it.total_fragments == 0 || it.total_fragments > 16 ||
            {1'b0, it.fragment_index} >= it.total_fragments) begin
            push_status(ST_BAD);
            return;
        end
        for (e = 0; e < 16; e++) begin
            if (valid[e]) begin
                if (hit < 0 && sess[e] == it.session_id && seqn[e] == it.sequence_req &&
                    addr[e] == it.source_ip && port[e] == it.source_port)
                    hit = e;
            end else if (spare < 0) begin
                spare = e;
            end
        end
        if (hit < 0) begin
            if (spare < 0) begin
                push_status(ST_FULL);
                return;
            end
            e         = spare;
            valid[e]  = 1;
            sess[e]   = it.session_id;
            seqn[e]   = it.sequence_req;
            addr[e]   = it.source_ip;
            port[e]   = it.source_port;
            total[e]  = it.total_fragments;
            rcvd[e]   = '0;
            bitmap[e] = '0;
            birth[e]  = tick;
        end else begin
            e = hit;
            if (total[e] != it.total_fragments) begin
                push_status(ST_MISMATCH);
                return;
            end
            if (bitmap[e][it.fragment_index]) begin
                push_status(ST_DUP);
                return;
            end
        end
        handles[e][it.fragment_index] = it.buffer_handle;
        bitmap[e][it.fragment_index]  = 1'b1;
        rcvd[e]                       = rcvd[e] + 5'd1;
        if (rcvd[e] >= total[e])
            release_entry(e, EV_COMPLETE);
        else
            push_status(ST_OK);
    endfunction

    function void check_beat(t_res got);
        t_res want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
            return;
        end
        want = pending_q.pop_front();
        if (got.status !== want.status || got.event_res !== want.event_res ||
            got.done_session !== want.done_session ||
            got.done_sequence !== want.done_sequence ||
            got.done_ip !== want.done_ip || got.done_port !== want.done_port ||
            got.done_total !== want.done_total ||
            got.slot_position !== want.slot_position ||
            got.slot_present !== want.slot_present ||
            got.slot_handle !== want.slot_handle || got.last !== want.last)
            report($sformatf("expected %h got %h", want, got));
    endfunction
endclass

module fragment_reassembly_tracker_tb;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_item       i_item;
    logic        busy;
    logic        o_strobe;
    t_res        o_res;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    reassembly_scoreboard sb;
    int                   cycles;

    // Key pool for the random part: reuse keys so datagrams actually complete
    t_item    key_pool[4];
    logic [4:0] key_total[4];

    fragment_reassembly_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor: check result beats first, then note an accepted command beat.
    // Both sides use the pre-edge values, so the order of events cannot matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_beat(o_res);
            if (start && !busy) sb.note_item(i_item);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one command beat and hold it until the block takes it
    task automatic send(t_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a random gap: mostly none or short, a few long
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 9) < 5) n = 0;
        else if ($urandom_range(0, 9) < 8) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drain: drop start, wait for every expected beat, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        sb.timeout = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_item rand_key();
        t_item it;
        it              = '0;
        it.command      = CMD_FRAG;
        it.session_id   = $urandom;
        it.sequence_req = $urandom;
        it.source_ip    = $urandom;
        it.source_port  = 16'($urandom);
        return it;
    endfunction

    function automatic t_item frag(t_item key, int tot, int idx);
        t_item it;
        it                 = key;
        it.command         = CMD_FRAG;
        it.total_fragments = tot[4:0];
        it.fragment_index  = idx[3:0];
        it.buffer_handle   = 16'($urandom);
        return it;
    endfunction

    function automatic t_item tick_item();
        t_item it;
        it         = rand_key();
        it.command = ~CMD_FRAG;
        it.buffer_handle = 16'($urandom);
        return it;
    endfunction

    task automatic refresh_pool();
        foreach (key_pool[k]) begin
            key_pool[k]  = rand_key();
            key_total[k] = ($urandom_range(0, 7) == 0) ? 5'd16 : 5'($urandom_range(1, 4));
        end
    endtask

    // One random beat: ticks, bad counts, fresh keys, and mostly pool fragments
    task automatic random_beat();
        int    r;
        int    k;
        t_item it;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (r < 25) begin
            it = tick_item();
        end else if (r < 32) begin
            it = frag(rand_key(), $urandom_range(0, 31), $urandom_range(0, 15));
        end else if (r < 37) begin
            it = frag(rand_key(), $urandom_range(1, 16), 0);
            it.fragment_index = 4'($urandom_range(0, it.total_fragments - 1));
        end else if (r < 41) begin
            // Same key, other total
            it = frag(key_pool[k], $urandom_range(1, 16), 0);
            it.fragment_index = 4'($urandom_range(0, it.total_fragments - 1));
        end else begin
            it = frag(key_pool[k], key_total[k], $urandom_range(0, key_total[k] - 1));
        end
        send(it);
        idle_gap();
    endtask

    initial begin
        t_item key;
        t_item fill_keys[16];
        sb         = new();
        cycles     = 0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: bad index or count, at the reset timeout
        send(frag(rand_key(), 0, 0));
        send(frag(rand_key(), 17, 3));
        send(frag(rand_key(), 3, 3));
        // One-fragment datagram completes at once
        send(frag(rand_key(), 1, 0));
        // Four fragments out of order with a duplicate and a count mismatch
        key = rand_key();
        send(frag(key, 4, 2));
        send(frag(key, 4, 2));
        send(frag(key, 5, 0));
        send(frag(key, 4, 0));
        send(frag(key, 4, 3));
        send(frag(key, 4, 1));
        // Fill all sixteen entries with 16-fragment datagrams, one slot each
        for (int i = 0; i < 16; i++) begin
            fill_keys[i] = rand_key();
            send(frag(fill_keys[i], 16, i));
        end
        // Table full, also for a one-fragment datagram
        send(frag(rand_key(), 1, 0));
        send(frag(rand_key(), 16, 15));
        // Zero timeout: each tick expires the lowest entry, then a quiet tick
        set_timeout(16'd0);
        for (int i = 0; i < 17; i++) send(tick_item());

        // Random phases across timeout settings, extremes among them
        set_timeout(16'd1);
        refresh_pool();
        for (int i = 0; i < 30; i++) random_beat();
        set_timeout(16'($urandom_range(2, 8)));
        refresh_pool();
        for (int i = 0; i < 40; i++) random_beat();
        set_timeout(16'hFFFF);
        refresh_pool();
        for (int i = 0; i < 30; i++) random_beat();
        set_timeout(16'd0);
        refresh_pool();
        for (int i = 0; i < 35; i++) random_beat();

        wait_idle();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
